/* hdl/xxh32_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package xxh32_pkg;

   localparam logic [31:0] PRIME1 = 32'h9e37_79b1;
   localparam logic [31:0] PRIME2 = 32'h85eb_ca77;
   localparam logic [31:0] PRIME3 = 32'hc2b2_ae3d;
   localparam logic [31:0] PRIME4 = 32'h27d4_eb2f;
   localparam logic [31:0] PRIME5 = 32'h1656_67b1;

   // Lane start values of a message.
   localparam logic [31:0] LANE0_INIT = PRIME1 + PRIME2;
   localparam logic [31:0] LANE1_INIT = PRIME2;
   localparam logic [31:0] LANE2_INIT = 32'h0000_0000;
   localparam logic [31:0] LANE3_INIT = 32'h0000_0000 - PRIME1;

   localparam logic [3:0] FILL_LAST_SLOT = 4'd12;
   localparam logic [2:0] COUNT_FULL     = 3'd4;

   // First operand of the shared multiplier.
   typedef enum logic [1:0] {
      MA_BUF,
      MA_HASH,
      MA_BYTE
   } mul_a_type;

   // Constant operand of the shared multiplier.
   typedef enum logic [2:0] {
      MK_P1,
      MK_P2,
      MK_P3,
      MK_P4,
      MK_P5
   } mul_k_type;

   // Update of the working hash register.
   typedef enum logic [3:0] {
      H_HOLD,
      H_SEED,
      H_ADD_LANE,
      H_ADD_LEN,
      H_ABSORB,
      H_WORD,
      H_BYTE,
      H_PROD,
      H_SHR15,
      H_SHR13
   } hash_op_type;

   typedef struct packed {
      logic        load;
      logic        clear;
      logic [1:0]  idx;
      logic        mul_en;
      mul_a_type   mul_a;
      mul_k_type   mul_k;
      hash_op_type hash_op;
      logic        lane_we;
      logic        digest_load;
   } dp_cmd_type;

   typedef struct packed {
      logic       take;
      logic       full;
      logic       seen;
      logic [1:0] words;
      logic [1:0] bytes;
   } dp_status_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
      return (v << r) | (v >> (32 - r));
   endfunction

endpackage

`default_nettype wire

/* hdl/xxh32_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module xxh32_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             in_word,
   input  logic [2:0]              in_count,
   input  logic                    in_last,
   input  xxh32_pkg::dp_cmd_type    cmd,
   output xxh32_pkg::dp_status_type status,
   output logic [31:0]             digest
);
   import xxh32_pkg::*;

   logic [31:0] lane_ff [4];
   logic [31:0] lane_in [4];
   logic [31:0] buf_ff  [4];
   logic [3:0]  fill_ff, fill_in;
   logic [31:0] len_ff, len_in;
   logic        seen_ff, seen_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] digest_ff;

   logic [2:0]  count;
   logic [31:0] masked_word;
   logic        write_word;
   logic [31:0] mul_a_val, mul_k_val;
   logic [31:0] lane_sel, lane_rot;
   logic [31:0] word_sel;
   logic [7:0]  byte_sel;

   assign count      = (in_count > COUNT_FULL) ? COUNT_FULL : in_count;
   assign write_word = cmd.load && status.take && (count != 3'd0);

   always_comb begin
      unique case (count)
         3'd0:    masked_word = 32'h0000_0000;
         3'd1:    masked_word = {24'd0, in_word[7:0]};
         3'd2:    masked_word = {16'd0, in_word[15:0]};
         3'd3:    masked_word = {8'd0, in_word[23:0]};
         default: masked_word = in_word;
      endcase
   end

   assign status.take  = in_last || (count == COUNT_FULL);
   assign status.full  = (count == COUNT_FULL) && (fill_ff == FILL_LAST_SLOT);
   assign status.seen  = seen_ff;
   assign status.words = fill_ff[3:2];
   assign status.bytes = fill_ff[1:0];

   assign lane_sel = lane_ff[cmd.idx];
   assign word_sel = buf_ff[fill_ff[3:2]];
   assign byte_sel = word_sel[8 * cmd.idx +: 8];

   // Merge rotations are 1, 7, 12 and 18 for lanes zero to three.
   always_comb begin
      unique case (cmd.idx)
         2'd0:    lane_rot = rotl32(lane_sel, 1);
         2'd1:    lane_rot = rotl32(lane_sel, 7);
         2'd2:    lane_rot = rotl32(lane_sel, 12);
         default: lane_rot = rotl32(lane_sel, 18);
      endcase
   end

   always_comb begin
      unique case (cmd.mul_a)
         MA_BUF:  mul_a_val = buf_ff[cmd.idx];
         MA_HASH: mul_a_val = hash_ff;
         default: mul_a_val = {24'd0, byte_sel};
      endcase
      unique case (cmd.mul_k)
         MK_P1:   mul_k_val = PRIME1;
         MK_P2:   mul_k_val = PRIME2;
         MK_P3:   mul_k_val = PRIME3;
         MK_P4:   mul_k_val = PRIME4;
         default: mul_k_val = PRIME5;
      endcase
   end

   assign prod_in = mul_a_val * mul_k_val;

   always_comb begin
      unique case (cmd.hash_op)
         H_HOLD:     hash_in = hash_ff;
         H_SEED:     hash_in = seen_ff ? 32'h0000_0000 : PRIME5;
         H_ADD_LANE: hash_in = hash_ff + lane_rot;
         H_ADD_LEN:  hash_in = hash_ff + len_ff;
         H_ABSORB:   hash_in = rotl32(lane_sel + prod_ff, 13);
         H_WORD:     hash_in = rotl32(hash_ff + prod_ff, 17);
         H_BYTE:     hash_in = rotl32(hash_ff + prod_ff, 11);
         H_PROD:     hash_in = prod_ff;
         H_SHR15:    hash_in = hash_ff ^ (hash_ff >> 15);
         H_SHR13:    hash_in = prod_ff ^ (prod_ff >> 13);
         default:    hash_in = hash_ff;
      endcase
   end

   always_comb begin
      lane_in = lane_ff;
      fill_in = fill_ff;
      len_in  = len_ff;
      seen_in = seen_ff;
      if (cmd.clear) begin
         lane_in[0] = LANE0_INIT;
         lane_in[1] = LANE1_INIT;
         lane_in[2] = LANE2_INIT;
         lane_in[3] = LANE3_INIT;
         fill_in    = 4'd0;
         len_in     = 32'h0000_0000;
         seen_in    = 1'b0;
      end else begin
         if (cmd.lane_we) begin
            lane_in[cmd.idx] = prod_ff;
         end
         if (write_word) begin
            // A completed stripe wraps the fill back to zero.
            fill_in = fill_ff + {1'b0, count};
            len_in  = len_ff + {29'd0, count};
            if (status.full) begin
               seen_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff[0] <= LANE0_INIT;
         lane_ff[1] <= LANE1_INIT;
         lane_ff[2] <= LANE2_INIT;
         lane_ff[3] <= LANE3_INIT;
         fill_ff    <= 4'd0;
         len_ff     <= 32'h0000_0000;
         seen_ff    <= 1'b0;
      end else begin
         lane_ff <= lane_in;
         fill_ff <= fill_in;
         len_ff  <= len_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_word) begin
         buf_ff[fill_ff[3:2]] <= masked_word;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      hash_ff <= hash_in;
      if (cmd.digest_load) begin
         digest_ff <= prod_ff ^ (prod_ff >> 16);
      end
   end

   assign digest = digest_ff;

endmodule

`default_nettype wire

/* hdl/xxh32_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module xxh32_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  xxh32_pkg::dp_status_type status,
   output xxh32_pkg::dp_cmd_type    cmd
);
   import xxh32_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ABS_MUL1,
      S_ABS_ROT,
      S_ABS_MUL2,
      S_ABS_WR,
      S_FIN_SEED,
      S_MERGE,
      S_ADD_LEN,
      S_WORD_MUL1,
      S_WORD_ROT,
      S_WORD_MUL2,
      S_WORD_WR,
      S_BYTE_MUL1,
      S_BYTE_ROT,
      S_BYTE_MUL2,
      S_BYTE_WR,
      S_AV_SHR15,
      S_AV_MUL2,
      S_AV_SHR13,
      S_AV_MUL3,
      S_AV_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0] idx_ff;
   logic       last_ff;
   logic       valid_ff;
   logic       out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   always_comb begin
      cmd             = '0;
      cmd.idx         = idx_ff;
      cmd.mul_a       = MA_BUF;
      cmd.mul_k       = MK_P1;
      cmd.hash_op     = H_HOLD;
      unique case (state_ff)
         S_IDLE:      cmd.load = req_tvalid;
         S_ABS_MUL1: begin
            cmd.mul_en = 1'b1;
            cmd.mul_k  = MK_P2;
         end
         S_ABS_ROT:   cmd.hash_op = H_ABSORB;
         S_ABS_MUL2: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = MA_HASH;
         end
         S_ABS_WR:    cmd.lane_we = 1'b1;
         S_FIN_SEED:  cmd.hash_op = H_SEED;
         S_MERGE:     cmd.hash_op = H_ADD_LANE;
         S_ADD_LEN:   cmd.hash_op = H_ADD_LEN;
         S_WORD_MUL1: begin
            cmd.mul_en = 1'b1;
            cmd.mul_k  = MK_P3;
         end
         S_WORD_ROT:  cmd.hash_op = H_WORD;
         S_WORD_MUL2: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = MA_HASH;
            cmd.mul_k  = MK_P4;
         end
         S_WORD_WR:   cmd.hash_op = H_PROD;
         S_BYTE_MUL1: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = MA_BYTE;
            cmd.mul_k  = MK_P5;
         end
         S_BYTE_ROT:  cmd.hash_op = H_BYTE;
         S_BYTE_MUL2: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = MA_HASH;
         end
         S_BYTE_WR:   cmd.hash_op = H_PROD;
         S_AV_SHR15:  cmd.hash_op = H_SHR15;
         S_AV_MUL2: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = MA_HASH;
            cmd.mul_k  = MK_P2;
         end
         S_AV_SHR13:  cmd.hash_op = H_SHR13;
         S_AV_MUL3: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = MA_HASH;
            cmd.mul_k  = MK_P3;
         end
         S_AV_OUT: begin
            cmd.digest_load = out_free;
            cmd.clear       = out_free;
         end
         default:     cmd.hash_op = H_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= 2'd0;
         last_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         // A new digest takes the output register as soon as it is free.
         if ((state_ff == S_AV_OUT) && out_free) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               idx_ff  <= 2'd0;
               last_ff <= req_tlast;
               if (req_tvalid && status.take) begin
                  if (status.full) begin
                     state_ff <= S_ABS_MUL1;
                  end else if (req_tlast) begin
                     state_ff <= S_FIN_SEED;
                  end
               end
            end
            S_ABS_MUL1: state_ff <= S_ABS_ROT;
            S_ABS_ROT:  state_ff <= S_ABS_MUL2;
            S_ABS_MUL2: state_ff <= S_ABS_WR;
            S_ABS_WR: begin
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff != 2'd3) begin
                  state_ff <= S_ABS_MUL1;
               end else if (last_ff) begin
                  state_ff <= S_FIN_SEED;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_FIN_SEED: begin
               idx_ff   <= 2'd0;
               state_ff <= status.seen ? S_MERGE : S_ADD_LEN;
            end
            S_MERGE: begin
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_ff <= S_ADD_LEN;
               end
            end
            S_ADD_LEN: begin
               idx_ff <= 2'd0;
               priority if (status.words != 2'd0) begin
                  state_ff <= S_WORD_MUL1;
               end else if (status.bytes != 2'd0) begin
                  state_ff <= S_BYTE_MUL1;
               end else begin
                  state_ff <= S_AV_SHR15;
               end
            end
            S_WORD_MUL1: state_ff <= S_WORD_ROT;
            S_WORD_ROT:  state_ff <= S_WORD_MUL2;
            S_WORD_MUL2: state_ff <= S_WORD_WR;
            S_WORD_WR: begin
               if (idx_ff != status.words - 2'd1) begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= S_WORD_MUL1;
               end else begin
                  idx_ff   <= 2'd0;
                  state_ff <= (status.bytes != 2'd0) ? S_BYTE_MUL1 : S_AV_SHR15;
               end
            end
            S_BYTE_MUL1: state_ff <= S_BYTE_ROT;
            S_BYTE_ROT:  state_ff <= S_BYTE_MUL2;
            S_BYTE_MUL2: state_ff <= S_BYTE_WR;
            S_BYTE_WR: begin
               if (idx_ff != status.bytes - 2'd1) begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= S_BYTE_MUL1;
               end else begin
                  state_ff <= S_AV_SHR15;
               end
            end
            S_AV_SHR15: state_ff <= S_AV_MUL2;
            S_AV_MUL2:  state_ff <= S_AV_SHR13;
            S_AV_SHR13: state_ff <= S_AV_MUL3;
            S_AV_MUL3:  state_ff <= S_AV_OUT;
            S_AV_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* hdl/xxhash32_digest_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streaming xxHash32 (seed zero) engine. A message arrives as little-endian
// 32-bit beats on the req channel, each with a byte count; only the beat
// marked with tlast may carry fewer than four bytes, and a count of zero on
// that beat just closes the message. A short beat without tlast is dropped,
// and counts above four act as four. One digest beat leaves on the rsp
// channel per message, after which the engine is back at its start state.
// A full beat that does not complete a 16-byte stripe is stored, and the
// engine stays ready. The beat that completes a stripe holds off the
// input while the four lanes are absorbed one after another through the
// single shared 32x32 multiplier, four steps per lane. The last beat then
// starts a finish of seed, lane merge if any stripe was absorbed, length,
// leftover words, leftover bytes, avalanche, paced by that multiplier. The
// digest sits in an output register, so the next message can start while
// it waits to be taken; the finish only stalls if the previous digest is
// still unclaimed. No clearing pass is needed after reset.

module xxhash32_digest_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] data_word, [34:32] byte_count, [39:35] zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] digest
);
   import xxh32_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   xxh32_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   xxh32_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .in_word  (req_tdata[31:0]),
      .in_count (req_tdata[34:32]),
      .in_last  (req_tlast),
      .cmd      (cmd),
      .status   (status),
      .digest   (rsp_tdata)
   );

endmodule

`default_nettype wire

/* hdl/xxh32_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module xxh32_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [39:0] req_tdata,
   input wire        req_tlast,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata
);

   // A waiting digest beat holds its value until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("digest beat changed or dropped while stalled");

   // Finishing a message always takes the engine away from the input.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still open right after a last beat");

   // A dropped short beat leaves the engine ready.
   a_short_dropped: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && (req_tdata[34:32] < 3'd4)
      |=> req_tready)
      else $error("short non-last beat was not ignored");

   // A new digest only comes out of a finish, never while idle.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("digest appeared without a finish");

endmodule

bind xxhash32_digest_core xxh32_checker u_xxh32_checker (.*);

`default_nettype wire
